### rtl/core/cfa_pkg.sv
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 13;

  localparam logic [REG_IDX_W-1:0] REG_MAX_ACCEL     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DECEL     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMFORT_DECEL = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEADWAY_TIME  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STANDSTILL    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_ADD    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_MULT   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLOSING_THR   = 3'd7;

  localparam logic [11:0] RST_MAX_ACCEL     = 12'd768;
  localparam logic [11:0] RST_MAX_DECEL     = 12'd2048;
  localparam logic [11:0] RST_COMFORT_DECEL = 12'd512;
  localparam logic [11:0] RST_HEADWAY_TIME  = 12'd256;
  localparam logic [12:0] RST_STANDSTILL    = 13'd512;
  localparam logic [11:0] RST_SAFETY_ADD    = 12'd512;
  localparam logic [11:0] RST_SAFETY_MULT   = 12'd768;
  localparam logic [11:0] RST_CLOSING_THR   = 12'd26;

  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_BRAKE    = 2'd1;
  localparam logic [1:0] MODE_APPROACH = 2'd2;
  localparam logic [1:0] MODE_FOLLOW   = 2'd3;

  // long dividers (five instances): numerator and divisor widths
  localparam int DIV_NW = 36;
  localparam int DIV_DW = 24;

  typedef struct packed {
    logic [15:0] own_speed;
    logic [15:0] target_speed;
    logic [9:0]  driver_factor;
    logic        leader_present;
    logic [15:0] leader_speed;
    logic [19:0] leader_gap;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] accel;
    logic [1:0]         mode;
  } out_item_t;

endpackage

### rtl/core/cfa_div.sv
`timescale 1ns / 1ps

module cfa_div #(
  parameter int NW = cfa_pkg::DIV_NW,
  parameter int DW = cfa_pkg::DIV_DW
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem [1:NW];
  logic [NW-1:0] nq  [1:NW];
  logic [DW-1:0] dn  [1:NW];

  // one restoring step: numerator bits shift out on top, quotient bits in below
  function automatic logic [DW+NW-1:0] div_step(logic [DW-1:0] r, logic [NW-1:0] q,
                                                logic [DW-1:0] d);
    logic [DW:0] tr;
    logic [DW:0] df;
    logic [DW+NW-1:0] res;
    tr = {r, q[NW-1]};
    df = tr - {1'b0, d};
    if (tr >= {1'b0, d}) begin
      res = {df[DW-1:0], q[NW-2:0], 1'b1};
    end else begin
      res = {tr[DW-1:0], q[NW-2:0], 1'b0};
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    {rem[1], nq[1]} <= div_step('0, num, den);
    dn[1] <= den;
    for (int k = 2; k <= NW; k++) begin
      {rem[k], nq[k]} <= div_step(rem[k-1], nq[k-1], dn[k-1]);
      dn[k] <= dn[k-1];
    end
  end

  assign quo = nq[NW];

endmodule

### rtl/core/car_following_acceleration.sv
`timescale 1ns / 1ps

// Car-following acceleration, one vehicle per beat.
// Input: raise start with item valid; a beat is taken at every clock edge
// with start high and busy low. busy is high only during reset, so a new
// vehicle can enter every cycle.
// Output: done pulses for one cycle with result (accel, mode). The result
// leaves the pipeline in the order the beats were taken.
// Throughput is one vehicle per cycle; a vehicle passes through the 12-step
// square-root pipeline and the 36-stage long dividers (one quotient bit
// per stage) that form the free, following and approach terms.
// The receiver cannot stall: results are shown for exactly one cycle.
// Configuration: cfg_wr writes cfg_data into register cfg_idx at the
// clock edge; write only while no vehicle is in flight.
// Reset (rst, synchronous) restores register defaults and drops all
// vehicles in flight; no done is produced for them.

module car_following_acceleration (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  cfa_pkg::in_item_t                   item,
  input  logic                                cfg_wr,
  input  logic [cfa_pkg::REG_IDX_W-1:0]       cfg_idx,
  input  logic [cfa_pkg::CFG_W-1:0]           cfg_data,
  output logic                                done,
  output cfa_pkg::out_item_t                  result
);

  localparam int DIV_END = 16 + cfa_pkg::DIV_NW;
  localparam int OUT_STG = DIV_END + 4;

  typedef struct packed {
    logic        lead;
    logic        brk;
    logic        fol;
    logic        clgt;
    logic        clpos;
    logic        dvneg;
    logic        dfneg;
    logic [20:0] room;
    logic [19:0] st;
  } tag_t;

  // configuration
  logic [11:0] max_accel, max_decel, comfort_decel, headway_time;
  logic [11:0] safety_add, safety_mult, closing_threshold;
  logic [12:0] standstill_dist;
  logic [11:0] t_eff, cd_eff;
  logic [23:0] t_sq;

  logic               accept;
  logic [OUT_STG:0]   vld;

  cfa_pkg::in_item_t  pin [0:14];
  logic [14:0]        pf [1:12];
  logic [12:0]        srem [1:12];
  logic [11:0]        sroot [1:12];
  logic [21:0]        mult_f;
  logic [27:0]        st_prod;

  logic [26:0]        prod13;
  logic signed [16:0] dvs13, cl13;
  logic [19:0]        dg14, st14;
  logic [15:0]        dvmag14, clmag14;
  logic               dvneg14, clpos14, clgt14;
  logic signed [21:0] diff15;
  logic               brk15, fol15, dvneg15, clpos15, clgt15, lead15;
  logic [15:0]        dvmag15, clmag15;
  logic [31:0]        c2_15;
  logic [19:0]        st15;
  logic [15:0]        dvmag16, clmag16;
  logic [31:0]        c2_16;
  logic [20:0]        room16;
  logic [19:0]        dfmag16;
  tag_t               tag16;
  tag_t               tag_hold;
  tag_t               tg [DIV_END-cfa_pkg::DIV_NW+1:DIV_END];

  logic [cfa_pkg::DIV_NW-1:0] q1, q2, q3, q4, q5;

  logic signed [37:0] fr53, a53, b53, ap53;
  logic [36:0]        sum53;
  tag_t               tg53, tg54;
  logic signed [37:0] freea54, fol54, ap54, amax_s;
  logic               app54;
  logic signed [37:0] folm, apm, acc_next, acc55, lo_s, fl;
  logic [1:0]         mode_next, mode55;
  logic signed [15:0] accel_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign t_eff  = (headway_time == 12'd0) ? 12'd1 : headway_time;
  assign cd_eff = (comfort_decel == 12'd0) ? 12'd1 : comfort_decel;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel         <= cfa_pkg::RST_MAX_ACCEL;
      max_decel         <= cfa_pkg::RST_MAX_DECEL;
      comfort_decel     <= cfa_pkg::RST_COMFORT_DECEL;
      headway_time      <= cfa_pkg::RST_HEADWAY_TIME;
      standstill_dist   <= cfa_pkg::RST_STANDSTILL;
      safety_add        <= cfa_pkg::RST_SAFETY_ADD;
      safety_mult       <= cfa_pkg::RST_SAFETY_MULT;
      closing_threshold <= cfa_pkg::RST_CLOSING_THR;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cfa_pkg::REG_MAX_ACCEL:     max_accel         <= cfg_data[11:0];
        cfa_pkg::REG_MAX_DECEL:     max_decel         <= cfg_data[11:0];
        cfa_pkg::REG_COMFORT_DECEL: comfort_decel     <= cfg_data[11:0];
        cfa_pkg::REG_HEADWAY_TIME:  headway_time      <= cfg_data[11:0];
        cfa_pkg::REG_STANDSTILL:    standstill_dist   <= cfg_data[12:0];
        cfa_pkg::REG_SAFETY_ADD:    safety_add        <= cfg_data[11:0];
        cfa_pkg::REG_SAFETY_MULT:   safety_mult       <= cfg_data[11:0];
        cfa_pkg::REG_CLOSING_THR:   closing_threshold <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // the user keeps config static while vehicles are in flight (not enforced here), so t_sq lag is harmless
  always_ff @(posedge clk) begin
    t_sq <= 24'(t_eff) * 24'(t_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_STG-1:0], accept};
    end
  end

  function automatic logic [24:0] sqrt_step(logic [12:0] r, logic [11:0] root,
                                            logic [1:0] two);
    logic [14:0] rs;
    logic [14:0] tr;
    logic [14:0] df;
    logic [24:0] res;
    rs = {r, two};
    tr = {1'b0, root, 2'b01};
    df = rs - tr;
    if (rs >= tr) begin
      res = {df[12:0], root[10:0], 1'b1};
    end else begin
      res = {rs[12:0], root[10:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic signed [37:0] sx(logic [cfa_pkg::DIV_NW-1:0] q);
    return $signed({2'b00, q});
  endfunction

  assign mult_f  = 22'(safety_mult) * 22'(pin[0].driver_factor);
  assign st_prod = 28'(pin[13].own_speed) * 28'(t_eff);

  // front end: square root of speed, safety factor, desired gap, speed and gap differences
  always_ff @(posedge clk) begin
    logic [23:0] xw;
    pin[0] <= item;
    for (int k = 1; k <= 14; k++) begin
      pin[k] <= pin[k-1];
    end
    pf[1] <= 15'(safety_add) + 15'(mult_f[21:8]);
    for (int k = 2; k <= 12; k++) begin
      pf[k] <= pf[k-1];
    end
    {srem[1], sroot[1]} <= sqrt_step(13'd0, 12'd0, pin[0].own_speed[15:14]);
    for (int k = 2; k <= 12; k++) begin
      xw = {pin[k-1].own_speed, 8'd0};
      {srem[k], sroot[k]} <= sqrt_step(srem[k-1], sroot[k-1], xw[25-2*k -: 2]);
    end

    prod13 <= 27'(pf[12]) * 27'(sroot[12]);
    dvs13  <= $signed({1'b0, pin[12].target_speed}) - $signed({1'b0, pin[12].own_speed});
    cl13   <= $signed({1'b0, pin[12].own_speed}) - $signed({1'b0, pin[12].leader_speed});

    dg14    <= 20'(standstill_dist) + 20'(prod13[26:8]);
    dvneg14 <= dvs13[16];
    dvmag14 <= dvs13[16] ? 16'(-dvs13) : dvs13[15:0];
    clpos14 <= !cl13[16] && (cl13 != 17'sd0);
    clmag14 <= cl13[16] ? 16'(-cl13) : cl13[15:0];
    clgt14  <= cl13 > $signed({5'd0, closing_threshold});
    st14    <= st_prod[27:8];

    diff15  <= $signed({2'b00, pin[14].leader_gap}) - $signed({2'b00, dg14});
    brk15   <= pin[14].leader_gap < dg14;
    fol15   <= {1'b0, pin[14].leader_gap, 1'b0} < (22'(dg14) + 22'({dg14, 1'b0}));
    c2_15   <= 32'(clmag14) * 32'(clmag14);
    dvmag15 <= dvmag14;
    dvneg15 <= dvneg14;
    clmag15 <= clmag14;
    clpos15 <= clpos14;
    clgt15  <= clgt14;
    st15    <= st14;
    lead15  <= pin[14].leader_present;

    room16  <= (diff15 >= 22'sd3) ? diff15[20:0] : 21'd3;
    dfmag16 <= diff15[21] ? 20'(-diff15) : diff15[19:0];
    dvmag16 <= dvmag15;
    clmag16 <= clmag15;
    c2_16   <= c2_15;
  end

  always_comb begin
    tag16.lead  = lead15;
    tag16.brk   = brk15;
    tag16.fol   = fol15;
    tag16.clgt  = clgt15;
    tag16.clpos = clpos15;
    tag16.dvneg = dvneg15;
    tag16.dfneg = diff15[21];
    tag16.room  = (diff15 >= 22'sd3) ? diff15[20:0] : 21'd3;
    tag16.st    = st15;
  end

  // tag captured at stage 16 alongside room16, travels with the dividers
  always_ff @(posedge clk) begin
    tg[DIV_END-cfa_pkg::DIV_NW+1] <= tag_hold;
    for (int k = DIV_END-cfa_pkg::DIV_NW+2; k <= DIV_END; k++) begin
      tg[k] <= tg[k-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_hold <= tag16;
  end

  cfa_div #(.NW(cfa_pkg::DIV_NW), .DW(cfa_pkg::DIV_DW)) u_div_free (
    .clk (clk),
    .num (cfa_pkg::DIV_NW'({dvmag16, 8'd0})),
    .den (cfa_pkg::DIV_DW'(t_eff)),
    .quo (q1)
  );

  cfa_div #(.NW(cfa_pkg::DIV_NW), .DW(cfa_pkg::DIV_DW)) u_div_close (
    .clk (clk),
    .num (cfa_pkg::DIV_NW'({clmag16, 8'd0})),
    .den (cfa_pkg::DIV_DW'(t_eff)),
    .quo (q2)
  );

  cfa_div #(.NW(cfa_pkg::DIV_NW), .DW(cfa_pkg::DIV_DW)) u_div_gap (
    .clk (clk),
    .num (cfa_pkg::DIV_NW'({dfmag16, 16'd0})),
    .den (cfa_pkg::DIV_DW'(t_sq)),
    .quo (q3)
  );

  cfa_div #(.NW(cfa_pkg::DIV_NW), .DW(cfa_pkg::DIV_DW)) u_div_comf (
    .clk (clk),
    .num (cfa_pkg::DIV_NW'(c2_16)),
    .den (cfa_pkg::DIV_DW'({cd_eff, 1'b0})),
    .quo (q4)
  );

  cfa_div #(.NW(cfa_pkg::DIV_NW), .DW(cfa_pkg::DIV_DW)) u_div_room (
    .clk (clk),
    .num (cfa_pkg::DIV_NW'(c2_16)),
    .den (cfa_pkg::DIV_DW'({room16, 1'b0})),
    .quo (q5)
  );

  assign amax_s = $signed({26'd0, max_accel});
  assign lo_s   = -$signed({26'd0, max_decel});

  // back end: signs, sums, mode decision, floor and saturation
  always_ff @(posedge clk) begin
    fr53  <= tg[DIV_END].dvneg ? -sx(q1) : sx(q1);
    a53   <= tg[DIV_END].clpos ? -sx(q2) : sx(q2);
    b53   <= tg[DIV_END].dfneg ? -sx(q3) : sx(q3);
    sum53 <= 37'(q4) + 37'(tg[DIV_END].st);
    ap53  <= -sx(q5);
    tg53  <= tg[DIV_END];

    freea54 <= (fr53 < amax_s) ? fr53 : amax_s;
    fol54   <= a53 + b53;
    app54   <= tg53.clgt && (37'(tg53.room) < sum53);
    ap54    <= ap53;
    tg54    <= tg53;

    acc55  <= acc_next;
    mode55 <= mode_next;

    result.accel <= accel_next;
    result.mode  <= mode55;
  end

  always_comb begin
    folm = (fol54 < freea54) ? fol54 : freea54;
    apm  = (ap54 < freea54) ? ap54 : freea54;
    acc_next  = freea54;
    mode_next = cfa_pkg::MODE_FREE;
    if (tg54.lead) begin
      if (tg54.brk) begin
        acc_next  = folm;
        mode_next = cfa_pkg::MODE_BRAKE;
      end else if (app54) begin
        acc_next  = apm;
        mode_next = cfa_pkg::MODE_APPROACH;
      end else if (tg54.fol) begin
        acc_next  = folm;
        mode_next = cfa_pkg::MODE_FOLLOW;
      end
    end
  end

  always_comb begin
    fl = (acc55 < lo_s) ? lo_s : acc55;
    if (fl > 38'sd32767) begin
      accel_next = 16'sh7fff;
    end else if (fl < -38'sd32768) begin
      accel_next = 16'sh8000;
    end else begin
      accel_next = fl[15:0];
    end
  end

  assign done = vld[OUT_STG];

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, OUT_STG+1))
    else $error("result beat without matching input beat");

  a_accel_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.accel <= 16'sd4095) && (result.accel >= -16'sd4095))
    else $error("accel outside register-bounded range");

  a_mode_leader: assert property (@(posedge clk) disable iff (rst)
    (done && (result.mode != cfa_pkg::MODE_FREE)) |->
      $past(item.leader_present, OUT_STG+1))
    else $error("non-free mode without a leader");

endmodule
